FILE: rtl/core/dvaag_pkg.sv
// ----------------------------------------------------------------------------
// dvaag_pkg
// shared types and constants for the dual vehicle altitude alignment gate
// ----------------------------------------------------------------------------
package dvaag_pkg;

  localparam int ALT_W   = 17;
  localparam int TOL_W   = 14;
  localparam int GAIN_W  = 8;
  localparam int POS_W   = 21;
  localparam int HGT_W   = 18;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 40;

  localparam logic [ALT_W-1:0] TARGET_RESET = ALT_W'(5000);

  localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MISSION = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ALT   = 3'd0,
    REG_MIN_ALT    = 3'd1,
    REG_MAX_ALT    = 3'd2,
    REG_LEVEL_TOL  = 3'd3,
    REG_REACH_TOL  = 3'd4,
    REG_HOME_TOL   = 3'd5,
    REG_SPLIT_LIM  = 3'd6,
    REG_TRIM_GAIN  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ALT_W-1:0]  base_altitude;
    logic [ALT_W-1:0]  min_altitude;
    logic [ALT_W-1:0]  max_altitude;
    logic [TOL_W-1:0]  level_tolerance;
    logic [TOL_W-1:0]  reach_tolerance;
    logic [TOL_W-1:0]  home_tolerance;
    logic [TOL_W-1:0]  split_limit;
    logic [GAIN_W-1:0] trim_gain;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic signed [POS_W-1:0]  lead_x;
    logic signed [POS_W-1:0]  lead_y;
    logic signed [HGT_W-1:0]  lead_height;
    logic signed [POS_W-1:0]  peer_x;
    logic signed [POS_W-1:0]  peer_y;
    logic signed [HGT_W-1:0]  peer_height;
    logic                     feeds_fresh;
    logic [MODE_W-1:0]        lead_mode;
    logic [MODE_W-1:0]        peer_mode;
    logic signed [HGT_W-1:0]  sight_error;
    logic                     sight_valid;
  } item_t;

  typedef struct packed {
    logic [ALT_W-1:0]   lead_target;
    logic [ALT_W-1:0]   peer_target;
    logic [COUNT_W-1:0] stable_count;
    logic               rearm_flag;
    logic               align_latch;
    logic               ready_latch;
  } state_t;

  typedef struct packed {
    logic [ALT_W-1:0] lead_return_alt;
    logic [ALT_W-1:0] peer_return_alt;
    logic             aligned;
    logic             start_ready;
  } result_t;

endpackage

FILE: rtl/core/dvaag_cfg_regs.sv
// ----------------------------------------------------------------------------
// dvaag_cfg_regs
// configuration register bank, written by index, no read-back
// ----------------------------------------------------------------------------
module dvaag_cfg_regs
  import dvaag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_altitude   <= ALT_W'(5000);
      cfg.min_altitude    <= ALT_W'(4000);
      cfg.max_altitude    <= ALT_W'(6000);
      cfg.level_tolerance <= TOL_W'(250);
      cfg.reach_tolerance <= TOL_W'(350);
      cfg.home_tolerance  <= TOL_W'(500);
      cfg.split_limit     <= TOL_W'(800);
      cfg.trim_gain       <= GAIN_W'(102);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_BASE_ALT:  cfg.base_altitude   <= cfg_data[ALT_W-1:0];
        REG_MIN_ALT:   cfg.min_altitude    <= cfg_data[ALT_W-1:0];
        REG_MAX_ALT:   cfg.max_altitude    <= cfg_data[ALT_W-1:0];
        REG_LEVEL_TOL: cfg.level_tolerance <= cfg_data[TOL_W-1:0];
        REG_REACH_TOL: cfg.reach_tolerance <= cfg_data[TOL_W-1:0];
        REG_HOME_TOL:  cfg.home_tolerance  <= cfg_data[TOL_W-1:0];
        REG_SPLIT_LIM: cfg.split_limit     <= cfg_data[TOL_W-1:0];
        REG_TRIM_GAIN: cfg.trim_gain       <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/dvaag_update.sv
// ----------------------------------------------------------------------------
// dvaag_update
// one-item update: altitude split, stability check, latches and trim
// ----------------------------------------------------------------------------
module dvaag_update
  import dvaag_pkg::*;
#(
  parameter int STABLE_TICKS       = 5,
  parameter int SIGHT_TOLERANCE_MM = 250
) (
  input  item_t   item,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_next,
  output result_t result
);

  localparam int SW = 22;
  localparam int PW = 28;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    mag = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic [ALT_W-1:0] clamp(input logic signed [SW-1:0] v,
                                             input logic [ALT_W-1:0] lo,
                                             input logic [ALT_W-1:0] hi);
    logic signed [SW-1:0] lo_w;
    logic signed [SW-1:0] hi_w;
    lo_w = $signed({{(SW-ALT_W){1'b0}}, lo});
    hi_w = $signed({{(SW-ALT_W){1'b0}}, hi});
    if (v < lo_w) begin
      clamp = lo;
    end else if (v > hi_w) begin
      clamp = hi;
    end else begin
      clamp = v[ALT_W-1:0];
    end
  endfunction

  logic [ALT_W-1:0]     band_lo;
  logic [ALT_W-1:0]     band_hi;
  logic [ALT_W-1:0]     base_eff;
  logic signed [SW-1:0] base_w;
  logic signed [SW-1:0] lh_w;
  logic signed [SW-1:0] ph_w;
  logic signed [SW-1:0] alt_gap;
  logic signed [SW-1:0] adj;
  logic signed [SW-1:0] lim;
  logic [ALT_W-1:0]     lead_cand;
  logic [ALT_W-1:0]     peer_cand;
  logic                 both_mission;
  logic                 both_wait;
  logic                 home_ok;
  logic                 ok;
  logic                 aligned;
  logic                 ready;
  logic signed [PW-1:0] trim_prod;
  logic signed [PW-1:0] trim_round;
  logic signed [SW-1:0] trim;
  logic [SW-1:0]        sight_mag;

  always_comb begin
    band_lo  = (cfg.min_altitude <= cfg.max_altitude) ? cfg.min_altitude : cfg.max_altitude;
    band_hi  = (cfg.min_altitude <= cfg.max_altitude) ? cfg.max_altitude : cfg.min_altitude;
    base_eff = clamp($signed({{(SW-ALT_W){1'b0}}, cfg.base_altitude}), band_lo, band_hi);
    base_w   = $signed({{(SW-ALT_W){1'b0}}, base_eff});

    lh_w = $signed({{(SW-HGT_W){item.lead_height[HGT_W-1]}}, item.lead_height});
    ph_w = $signed({{(SW-HGT_W){item.peer_height[HGT_W-1]}}, item.peer_height});
    alt_gap = lh_w - ph_w;

    // half split, arithmetic shift then symmetric limit
    lim = $signed({{(SW-TOL_W){1'b0}}, cfg.split_limit});
    adj = alt_gap >>> 1;
    if (adj > lim) begin
      adj = lim;
    end
    if (adj < -lim) begin
      adj = -lim;
    end
    lead_cand = clamp(base_w - adj, band_lo, band_hi);
    peer_cand = clamp(base_w + adj, band_lo, band_hi);

    both_mission = (item.lead_mode == MODE_MISSION) && (item.peer_mode == MODE_MISSION);
    both_wait    = (item.lead_mode == MODE_WAIT) && (item.peer_mode == MODE_WAIT);

    home_ok =
      (mag(SW'(item.lead_x)) <= SW'(cfg.home_tolerance)) &&
      (mag(SW'(item.lead_y)) <= SW'(cfg.home_tolerance)) &&
      (mag(SW'(item.peer_x)) <= SW'(cfg.home_tolerance)) &&
      (mag(SW'(item.peer_y)) <= SW'(cfg.home_tolerance));

    // rounded trim, halves toward plus infinity
    trim_prod  = $signed({{(PW-GAIN_W){1'b0}}, cfg.trim_gain}) *
                 $signed({{(PW-HGT_W){item.sight_error[HGT_W-1]}}, item.sight_error});
    trim_round = trim_prod + PW'(128);
    trim       = SW'(trim_round >>> 8);
    sight_mag  = mag($signed({{(SW-HGT_W){item.sight_error[HGT_W-1]}}, item.sight_error}));

    state_next = state;
    aligned    = 1'b0;
    ready      = 1'b0;
    ok         = 1'b0;

    if (item.kind == KIND_RESET) begin
      state_next.rearm_flag   = 1'b1;
      state_next.stable_count = '0;
      state_next.align_latch  = 1'b0;
      state_next.ready_latch  = 1'b0;
      state_next.lead_target  = base_eff;
      state_next.peer_target  = base_eff;
    end else begin
      if (both_mission) begin
        state_next.rearm_flag   = 1'b0;
        state_next.align_latch  = 1'b0;
        state_next.ready_latch  = 1'b0;
        state_next.stable_count = '0;
        state_next.lead_target  = base_eff;
        state_next.peer_target  = base_eff;
      end

      if (item.feeds_fresh && (state_next.rearm_flag || !both_mission)) begin
        if (state_next.align_latch) begin
          aligned = 1'b1;
        end else begin
          if (!state_next.ready_latch) begin
            state_next.lead_target = lead_cand;
            state_next.peer_target = peer_cand;
          end
          ok = home_ok &&
            (mag(lh_w - $signed({{(SW-ALT_W){1'b0}}, state_next.lead_target}))
               <= SW'(cfg.reach_tolerance)) &&
            (mag(ph_w - $signed({{(SW-ALT_W){1'b0}}, state_next.peer_target}))
               <= SW'(cfg.reach_tolerance)) &&
            (mag(alt_gap) <= SW'(cfg.level_tolerance));
          if (ok) begin
            if (state_next.stable_count != {COUNT_W{1'b1}}) begin
              state_next.stable_count = state_next.stable_count + COUNT_W'(1);
            end
          end else begin
            state_next.stable_count = '0;
            state_next.ready_latch  = 1'b0;
          end
          aligned = (state_next.stable_count >= COUNT_W'(STABLE_TICKS));
          if (aligned) begin
            state_next.align_latch = 1'b1;
          end
        end

        if (aligned && both_wait && item.sight_valid) begin
          if (sight_mag <= SW'(SIGHT_TOLERANCE_MM)) begin
            state_next.ready_latch = 1'b1;
            ready = 1'b1;
          end else begin
            state_next.lead_target = clamp(
              $signed({{(SW-ALT_W){1'b0}}, state_next.lead_target}) - trim,
              band_lo, band_hi);
          end
        end
      end
    end

    result.lead_return_alt = state_next.lead_target;
    result.peer_return_alt = state_next.peer_target;
    result.aligned         = aligned;
    result.start_ready     = ready || state_next.ready_latch;
  end

endmodule

FILE: rtl/core/dual_vehicle_altitude_alignment_gate.sv
// ----------------------------------------------------------------------------
// dual_vehicle_altitude_alignment_gate
// return altitude split, alignment latch and perception trim gate
// ----------------------------------------------------------------------------
// One item per clock cycle is taken while the master side takes results. An
// accepted item sits in an input register while a single combinational
// update computes the new gate state and the result, which is written into
// the result register; a tick's result passes through the input register and
// then the result register before it appears on the master side, and a reset
// request updates the state and gives no result. The input register advances
// whenever the result register is empty or being emptied, and a reset request
// always advances; a tick held behind a result that the master side has not
// taken keeps s_tready low until m_tready rises.
module dual_vehicle_altitude_alignment_gate
  import dvaag_pkg::*;
#(
  parameter int STABLE_TICKS       = 5,
  parameter int SIGHT_TOLERANCE_MM = 250
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // lead_x, lead_y, lead_height, peer_x, peer_y, peer_height, feeds_fresh,
  // lead_mode, peer_mode, sight_error, sight_valid
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // lead_return_alt, peer_return_alt, aligned, start_ready, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  dvaag_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dvaag_update #(
    .STABLE_TICKS       (STABLE_TICKS),
    .SIGHT_TOLERANCE_MM (SIGHT_TOLERANCE_MM)
  ) u_update (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (res_next)
  );

  assign advance  = in_valid && ((in_item.kind == KIND_RESET) || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind        <= s_tuser;
      in_item.lead_x      <= s_tdata[20:0];
      in_item.lead_y      <= s_tdata[41:21];
      in_item.lead_height <= s_tdata[59:42];
      in_item.peer_x      <= s_tdata[80:60];
      in_item.peer_y      <= s_tdata[101:81];
      in_item.peer_height <= s_tdata[119:102];
      in_item.feeds_fresh <= s_tdata[120];
      in_item.lead_mode   <= s_tdata[122:121];
      in_item.peer_mode   <= s_tdata[124:123];
      in_item.sight_error <= s_tdata[142:125];
      in_item.sight_valid <= s_tdata[143];
    end
  end

  // gate state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.lead_target  <= TARGET_RESET;
      state.peer_target  <= TARGET_RESET;
      state.stable_count <= '0;
      state.rearm_flag   <= 1'b0;
      state.align_latch  <= 1'b0;
      state.ready_latch  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_item.kind == KIND_TICK)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_item.kind == KIND_TICK)) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res.start_ready, out_res.aligned,
                     out_res.peer_return_alt, out_res.lead_return_alt};

endmodule
